// File: sv/msrb_pkg.sv
// Package for the multichannel sample ring buffer.
// Holds sizes, opcodes, status codes, the stage info struct and helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msrb_pkg;

	// Store geometry.
	localparam int CHANNELS = 8;
	localparam int DEPTH    = 1024;
	localparam int CH_W     = $clog2(CHANNELS);
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int LEN_W    = PTR_W + 1;
	localparam int ADDR_W   = CH_W + PTR_W;

	// Fixed field widths.
	localparam int DATA_W   = 32;
	localparam int OP_W     = 2;
	localparam int CHAN_W   = 3;
	localparam int OFF_W    = 10;
	localparam int AVAIL_W  = 10;
	localparam int CFG_W    = 11;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
	localparam logic [OP_W-1:0] OP_COUNT = 2'd3;

	// Status codes.
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	// What the front end hands to the result stage for each transfer.
	typedef struct packed {
		logic             chan_ok;
		logic             is_pop;
		logic             rd_ok;
		logic             status;
		logic [LEN_W-1:0] rp;
		logic [LEN_W-1:0] wp;
		logic [LEN_W-1:0] len;
	} info_t;

	// A single precision pattern with an all-ones exponent and a nonzero mantissa.
	function automatic logic is_nan(input logic [DATA_W-1:0] x);
		is_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	// Length in use: zero acts as one, anything above the depth acts as the depth.
	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
		logic [LEN_W-1:0] n;
		if (v == '0) begin
			n = LEN_W'(1);
		end else if (int'(v) > DEPTH) begin
			n = LEN_W'(DEPTH);
		end else begin
			n = LEN_W'(v);
		end
		eff_len = n;
	endfunction

endpackage

`default_nettype wire

// File: sv/msrb_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Read data updates only on a read and holds otherwise. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: a write or a registered read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/msrb_ctrl.sv
// Front end of the ring buffer: per-channel pointers, write marks and length register.
// Forms the store address for each transfer and the info for the result stage.
// Depends on msrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msrb_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [msrb_pkg::OP_W-1:0]     opcode,
	input  wire logic [msrb_pkg::CHAN_W-1:0]   channel,
	input  wire logic [msrb_pkg::DATA_W-1:0]   sample_in,
	input  wire logic [msrb_pkg::OFF_W-1:0]    offset,
	input  wire logic                          cfg_we,
	input  wire logic [msrb_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                               ram_en,
	output logic                               ram_we,
	output logic      [msrb_pkg::ADDR_W-1:0]   ram_addr,
	output logic      [msrb_pkg::DATA_W-1:0]   ram_wdata,
	output msrb_pkg::info_t                    info
);
	import msrb_pkg::*;

	logic [PTR_W-1:0] rp_q [CHANNELS];
	logic [PTR_W-1:0] wp_q [CHANNELS];
	logic [LEN_W-1:0] hw_q [CHANNELS];
	logic [LEN_W-1:0] len_q;

	logic [CH_W-1:0]  ch;
	logic             chan_ok;
	logic [LEN_W-1:0] rp, wp, rp_inc, wp_inc, rp_next, wp_next;
	logic [LEN_W-1:0] rp_new, wp_new, off_l, peek_idx, hw;
	logic             peek_bad;
	logic [PTR_W-1:0] slot;
	logic             is_push;

	// Current pointers of the addressed channel, forced into range.
	always_comb begin
		ch      = channel[CH_W-1:0];
		chan_ok = int'(channel) < CHANNELS;
		hw      = hw_q[ch];
		rp      = {1'b0, rp_q[ch]};
		wp      = {1'b0, wp_q[ch]};
		if (rp >= len_q) rp = '0;
		if (wp >= len_q) wp = '0;
		rp_inc   = rp + LEN_W'(1);
		wp_inc   = wp + LEN_W'(1);
		rp_next  = (rp_inc >= len_q) ? '0 : rp_inc;
		wp_next  = (wp_inc >= len_q) ? '0 : wp_inc;
		off_l    = LEN_W'(offset);
		peek_bad = off_l >= len_q;
		peek_idx = (rp >= off_l) ? (rp - off_l) : (rp + len_q - off_l);
	end

	// Decode the operation into a store access and the pointers left behind.
	always_comb begin
		is_push      = 1'b0;
		slot         = rp[PTR_W-1:0];
		rp_new       = rp;
		wp_new       = wp;
		info         = '0;
		info.chan_ok = chan_ok;
		info.len     = len_q;
		unique case (opcode)
			OP_PUSH: begin
				is_push = 1'b1;
				slot    = wp[PTR_W-1:0];
				wp_new  = wp_next;
			end
			OP_POP: begin
				slot        = rp[PTR_W-1:0];
				info.is_pop = 1'b1;
				info.rd_ok  = rp < hw;
				rp_new      = rp_next;
			end
			OP_PEEK: begin
				slot = peek_idx[PTR_W-1:0];
				if (peek_bad) begin
					info.status = ST_RANGE;
				end else begin
					info.rd_ok = peek_idx < hw;
				end
			end
			OP_COUNT: begin
				slot = rp[PTR_W-1:0];
			end
			default: begin
				slot = rp[PTR_W-1:0];
			end
		endcase
		if (!chan_ok) begin
			info.rd_ok  = 1'b0;
			info.is_pop = 1'b0;
			info.status = ST_OK;
		end else begin
			info.rp = rp_new;
			info.wp = wp_new;
		end
		ram_en    = accept && chan_ok;
		ram_we    = is_push;
		ram_addr  = {ch, slot};
		ram_wdata = is_nan(sample_in) ? '0 : sample_in;
	end

	// Pointer file and write marks: a slot below the mark has been written since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(DEPTH);
			for (int i = 0; i < CHANNELS; i++) begin
				rp_q[i] <= '0;
				wp_q[i] <= '0;
				hw_q[i] <= '0;
			end
		end else if (cfg_we) begin
			len_q <= eff_len(cfg_wdata);
			for (int i = 0; i < CHANNELS; i++) begin
				rp_q[i] <= '0;
				wp_q[i] <= '0;
			end
		end else if (accept && chan_ok) begin
			rp_q[ch] <= rp_new[PTR_W-1:0];
			wp_q[ch] <= wp_new[PTR_W-1:0];
			if (is_push && (wp >= hw)) begin
				hw_q[ch] <= wp_inc;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/msrb_out.sv
// Result side of the ring buffer: the read stage and the output register.
// Filters NaN on pop, computes the fill level and drives the result stream.
// Depends on msrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msrb_out (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire msrb_pkg::info_t                info,
	input  wire logic [msrb_pkg::DATA_W-1:0]    ram_rdata,
	output logic                                in_ready,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [msrb_pkg::DATA_W-1:0]    sample_out,
	output logic      [msrb_pkg::AVAIL_W-1:0]   available,
	output logic                                status
);
	import msrb_pkg::*;

	logic             valid_s1;
	info_t            info_s1;
	logic             out_valid_q;
	logic [DATA_W-1:0] sample_q;
	logic [AVAIL_W-1:0] avail_q;
	logic             status_q;

	logic             advance;
	logic [DATA_W-1:0] smp;
	logic [LEN_W-1:0] avail;

	// The read stage moves on whenever the output register is empty or being taken.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Result value and fill level from the read stage.
	always_comb begin
		smp = '0;
		if (info_s1.rd_ok) begin
			smp = (info_s1.is_pop && is_nan(ram_rdata)) ? '0 : ram_rdata;
		end
		avail = (info_s1.wp >= info_s1.rp) ? (info_s1.wp - info_s1.rp)
			: (info_s1.wp + info_s1.len - info_s1.rp);
		if (!info_s1.chan_ok) avail = '0;
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q <= smp;
			avail_q  <= avail[AVAIL_W-1:0];
			status_q <= info_s1.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign available  = avail_q;
	assign status     = status_q;

endmodule

`default_nettype wire

// File: sv/multichannel_sample_ring_buffer.sv
// Top level of the multichannel sample ring buffer.
// Instantiates msrb_ctrl, msrb_ram and msrb_out; depends on msrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Eight channels of circular sample storage, each up to 1024 words, held in one
// 8192 x 32 single-port RAM addressed by channel and slot. Every transfer on the
// input stream is one operation (push, pop, peek or count) and produces exactly one
// result transfer. One item is taken per clock while s_tready is high; the single
// RAM port sets that figure, since each item makes at most one access. A result
// passes through the read stage and then the output register before it is offered
// on the output. The input stays ready until both the read stage and the output
// register hold results and the output is stalled. No clearing pass runs after
// reset: a per-channel write mark tracks how far the write pointer has ever
// advanced, and a slot at or above it reads as zero. Writing buffer_length zeroes
// all pointers but keeps the stored samples; write it only while the block is idle.
module multichannel_sample_ring_buffer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // sample_in[31:0], offset[41:32], zero pad
	input  wire logic [4:0]  s_tuser,  // opcode[1:0], channel[4:2]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [47:0] m_tdata,  // sample_out[31:0], available[41:32], zero pad
	output logic      [0:0]  m_tuser,  // status[0]
	// Configuration: buffer_length.
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata
);
	import msrb_pkg::*;

	logic               accept;
	logic               ram_en, ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [DATA_W-1:0]  ram_wdata, ram_rdata;
	info_t              info;
	logic [DATA_W-1:0]  sample_out;
	logic [AVAIL_W-1:0] available;
	logic               status;

	assign accept = s_tvalid && s_tready;

	msrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (s_tuser[1:0]),
		.channel   (s_tuser[4:2]),
		.sample_in (s_tdata[31:0]),
		.offset    (s_tdata[41:32]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ram_en    (ram_en),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.info      (info)
	);

	msrb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CHANNELS * DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	msrb_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.info       (info),
		.ram_rdata  (ram_rdata),
		.in_ready   (s_tready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.sample_out (sample_out),
		.available  (available),
		.status     (status)
	);

	// Pack the result fields.
	assign m_tdata = {6'd0, available, sample_out};
	assign m_tuser = status;

endmodule

`default_nettype wire

// File: sv/msrb_checker.sv
// Port-level checker for the multichannel sample ring buffer, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none

module msrb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The input only stalls when a result is waiting and the output is stalled.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");

	// A peek out of range returns zero.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
		else $error("out-of-range peek returned data");

	// The padding bits of a result are zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:42] == 6'd0)
		else $error("nonzero padding in result");

endmodule

bind multichannel_sample_ring_buffer msrb_checker u_chk (.*);

`default_nettype wire

// File: test/sample_ring_predictor.sv
// Result predictor and checker for the multichannel sample ring buffer testbench.
// Watches the input, result and configuration ports; depends on msrb_pkg.
`timescale 1ns / 1ps

module sample_ring_predictor
	import msrb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,  // sample_in[31:0], offset[41:32], zero pad
	input  wire logic [4:0]  s_tuser,  // opcode[1:0], channel[4:2]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [47:0] m_tdata,  // sample_out[31:0], available[41:32], zero pad
	input  wire logic [0:0]  m_tuser,  // status[0]
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic [DATA_W-1:0]  sample;
		logic [AVAIL_W-1:0] avail;
		logic               status;
	} ring_result_t;

	// Shadow copy of the sample slots, the pointers and the length register.
	logic [DATA_W-1:0] slot_mem [CHANNELS*DEPTH];
	int unsigned       rd_ptr [CHANNELS];
	int unsigned       wr_ptr [CHANNELS];
	logic [CFG_W-1:0]  length_reg;

	ring_result_t      pending_results [$];
	int                mismatches;

	// True for an all-ones exponent with a nonzero fraction.
	function automatic logic nan_pattern(input logic [DATA_W-1:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != '0);
	endfunction

	// Performs one operation on the shadow state and returns the result it yields.
	function automatic ring_result_t apply_ring_op(input logic [OP_W-1:0] op,
			input logic [CHAN_W-1:0] ch, input logic [DATA_W-1:0] smp,
			input logic [OFF_W-1:0] off);
		int unsigned  len;
		int unsigned  rp;
		int unsigned  wp;
		int unsigned  base;
		int unsigned  slot;
		ring_result_t r;
		r = '0;
		if (int'(ch) >= CHANNELS) begin
			return r;
		end
		// A length of zero behaves as one, anything past the depth as the depth.
		if (length_reg == '0) begin
			len = 1;
		end else if (int'(length_reg) > DEPTH) begin
			len = DEPTH;
		end else begin
			len = length_reg;
		end
		base = int'(ch) * DEPTH;
		rp = (rd_ptr[ch] >= len) ? 0 : rd_ptr[ch];
		wp = (wr_ptr[ch] >= len) ? 0 : wr_ptr[ch];
		case (op)
			OP_PUSH: begin
				slot_mem[base + wp] = nan_pattern(smp) ? '0 : smp;
				wp = (wp + 1 >= len) ? 0 : wp + 1;
			end
			OP_POP: begin
				r.sample = nan_pattern(slot_mem[base + rp]) ? '0 : slot_mem[base + rp];
				rp = (rp + 1 >= len) ? 0 : rp + 1;
			end
			OP_PEEK: begin
				// Offsets at or past the length are flagged and read nothing.
				if (off >= len) begin
					r.status = ST_RANGE;
				end else begin
					slot = (rp >= off) ? rp - off : rp + len - off;
					r.sample = slot_mem[base + slot];
				end
			end
			default: begin
			end
		endcase
		rd_ptr[ch] = rp;
		wr_ptr[ch] = wp;
		r.avail = AVAIL_W'((rp <= wp) ? wp - rp : wp + len - rp);
		return r;
	endfunction

	// Track configuration writes, check each result transfer, predict each input transfer.
	always @(posedge clk or negedge arst_n) begin
		ring_result_t want;
		ring_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS*DEPTH; i++) begin
				slot_mem[i] = '0;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				rd_ptr[c] = 0;
				wr_ptr[c] = 0;
			end
			length_reg = CFG_W'(1024);
			pending_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				length_reg = cfg_wdata;
				for (int c = 0; c < CHANNELS; c++) begin
					rd_ptr[c] = 0;
					wr_ptr[c] = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				got.sample = m_tdata[31:0];
				got.avail  = m_tdata[41:32];
				got.status = m_tuser[0];
				if (pending_results.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual %h",
						$time, got);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (got.sample !== want.sample) begin
						$display("%0t: sample_out expected %h actual %h",
							$time, want.sample, got.sample);
						mismatches++;
					end
					if (got.avail !== want.avail) begin
						$display("%0t: available expected %0d actual %0d",
							$time, want.avail, got.avail);
						mismatches++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, got.status);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				pending_results.push_back(apply_ring_op(s_tuser[1:0], s_tuser[4:2],
					s_tdata[31:0], s_tdata[41:32]));
			end
		end
		fail_count  <= mismatches;
		outstanding <= pending_results.size();
	end

endmodule

// File: test/multichannel_sample_ring_buffer_test.sv
// Top of the multichannel sample ring buffer testbench: clock, reset, stimulus, verdict.
// Depends on msrb_pkg, multichannel_sample_ring_buffer and sample_ring_predictor.
`timescale 1ns / 1ps

module multichannel_sample_ring_buffer_test;
	import msrb_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;  // sample_in[31:0], offset[41:32], zero pad
	logic [4:0]  s_tuser   = '0;  // opcode[1:0], channel[4:2]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;         // sample_out[31:0], available[41:32], zero pad
	logic [0:0]  m_tuser;         // status[0]
	logic        cfg_we    = 1'b0;
	logic [10:0] cfg_wdata = '0;

	int   fail_count;
	int   outstanding;
	int   tx_idle_pct  = 22;
	int   rx_stall_pct = 79;
	logic hold_req     = 1'b0;
	int   eff_len_now  = 1024;
	int   cycle_count  = 0;

	multichannel_sample_ring_buffer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sample_ring_predictor u_predictor (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit.
	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin
		int  hold_left;
		bit  hold_used;
		hold_left = 0;
		hold_used = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// Offers one item after a random gap and returns at the edge of its transfer.
	// The valid stays up so a following item can go out back to back.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
			input logic [DATA_W-1:0] smp, input logic [OFF_W-1:0] off);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, off, smp};
		s_tuser  <= {ch, op};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Writes the length register; only called while the block is idle.
	task automatic set_length(input int value);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_len_now = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : value);
		@(posedge clk);
	endtask

	// Random operations, half of them aimed at one channel so it fills and wraps.
	task automatic send_random(input int count);
		logic [OP_W-1:0]   op;
		logic [CHAN_W-1:0] ch;
		logic [DATA_W-1:0] smp;
		logic [OFF_W-1:0]  off;
		int                pick;
		int                hot;
		hot = $urandom_range(0, CHANNELS - 1);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			op = (pick < 40) ? OP_PUSH : (pick < 70) ? OP_POP : (pick < 90) ? OP_PEEK : OP_COUNT;
			ch = ($urandom_range(0, 1) == 0) ? CHAN_W'(hot) : CHAN_W'($urandom_range(0, 7));
			// Mix in NaN, infinity and the all-zero and all-one patterns.
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				smp = {1'($urandom), 8'hFF, 23'($urandom_range(1, 23'h7FFFFF))};
			end else if (pick < 15) begin
				smp = {1'($urandom), 8'hFF, 23'd0};
			end else if (pick < 18) begin
				smp = '0;
			end else if (pick < 20) begin
				smp = '1;
			end else begin
				smp = $urandom;
			end
			// Offsets mostly in range, some right at the length boundary.
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				off = OFF_W'($urandom_range(0, eff_len_now - 1));
			end else if (pick < 70) begin
				off = OFF_W'((eff_len_now > 1023 || $urandom_range(0, 1) == 0) ?
					eff_len_now - 1 : eff_len_now);
			end else begin
				off = OFF_W'($urandom_range(0, 1023));
			end
			send_item(op, ch, smp, off);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int lengths [9];
		lengths = '{3, 1024, 0, 17, 2047, 1, 64, 1023, 2};
		lengths[7] = $urandom_range(2, 1024);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset length: deepest peek reads an unwritten slot, which returns zero.
		send_item(OP_PEEK, 3'd3, 32'h0, 10'd1023);
		send_item(OP_COUNT, 3'd7, 32'hFFFFFFFF, 10'd0);
		drain();

		// Short ring: NaN removal, overwrite when full, peek range, pop when empty.
		set_length(4);
		send_item(OP_PUSH, 3'd0, 32'h7FC00000, 10'd0);
		send_item(OP_PUSH, 3'd0, 32'h7F800000, 10'd0);
		send_item(OP_PUSH, 3'd0, 32'hFFFFFFFF, 10'd0);
		send_item(OP_PUSH, 3'd0, 32'h00000000, 10'd0);
		send_item(OP_COUNT, 3'd0, 32'h0, 10'd0);
		send_item(OP_PUSH, 3'd0, 32'h80000001, 10'd0);
		send_item(OP_PEEK, 3'd0, 32'h0, 10'd0);
		send_item(OP_PEEK, 3'd0, 32'h0, 10'd3);
		send_item(OP_PEEK, 3'd0, 32'h0, 10'd4);
		send_item(OP_PEEK, 3'd0, 32'h0, 10'd1023);
		send_item(OP_POP, 3'd7, 32'h0, 10'd0);
		send_item(OP_COUNT, 3'd7, 32'h0, 10'd0);
		send_item(OP_POP, 3'd0, 32'h0, 10'd0);
		send_item(OP_POP, 3'd0, 32'h0, 10'd0);
		send_item(OP_COUNT, 3'd0, 32'h0, 10'd1023);
		drain();

		// Zero length acts as a single slot.
		set_length(0);
		send_item(OP_PUSH, 3'd5, 32'h3F800000, 10'd0);
		send_item(OP_POP, 3'd5, 32'h0, 10'd0);
		send_item(OP_PEEK, 3'd5, 32'h0, 10'd0);
		send_item(OP_PEEK, 3'd5, 32'h0, 10'd1);
		send_item(OP_COUNT, 3'd5, 32'h0, 10'd0);
		drain();

		// Three idling regimes, three lengths each.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 22;
					rx_stall_pct <= 79;
				end
				1: begin
					tx_idle_pct = 79;
					rx_stall_pct <= 22;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
			endcase
			for (int seg = 0; seg < 3; seg++) begin
				set_length(lengths[phase*3 + seg]);
				send_random(210);
				drain();
			end
		end

		// Long receiver hold-off while the sender keeps offering.
		set_length(5);
		hold_req <= 1'b1;
		send_random(60);
		drain();

		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
